/* rtl/dnd_pkg.sv */
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants of the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnd_pkg;

   localparam int PACKET_BYTES   = 1024;
   localparam int PKT_AW         = $clog2(PACKET_BYTES);
   localparam int ADDR_W         = 10;
   // Walk positions run one past the end of the store so that the range check can see them.
   localparam int POS_W          = ((PKT_AW > ADDR_W) ? PKT_AW : ADDR_W) + 1;
   localparam int NAME_MAX_CHARS = 255;
   localparam int NAME_W         = $clog2(NAME_MAX_CHARS + 1);

   localparam logic [7:0] PTR_MARK = 8'd192;
   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [2:0] GROUP_FULL = 3'd4;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TOO_LONG = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } walk_state_type;

   typedef enum logic [1:0] {
      K_LEN,
      K_PTR,
      K_LABEL
   } part_kind_type;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] char_a;
      logic [7:0] char_b;
      logic [7:0] char_c;
      logic [7:0] char_d;
      logic [2:0] char_count;
      logic       last;
      logic [9:0] consumed;
      logic [1:0] status;
   } rsp_payload_type;

endpackage

/* rtl/dnd_ifs.sv */
// ----------------------------------------------------------------------------
// dnd_ifs
// Valid/ready channels for requests and name results.
// ----------------------------------------------------------------------------
interface dnd_req_if;
   import dnd_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dnd_rsp_if;
   import dnd_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/dns_name_decompressor.sv */
// A decode request starts in the idle state, then walks the packet bytes one by one
// (length, label and pointer bytes) and posts the final group from the done state.
// The walk is bound by the single read port of the packet memory; output back-pressure
// stalls it.
// Reset clears the control state only; the packet memory is undefined until written.
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Stores packet bytes and expands compressed DNS names into groups of four characters.
// ----------------------------------------------------------------------------
module dns_name_decompressor (
   input logic       clock,
   input logic       reset,
   dnd_req_if.sink   req_ch,
   dnd_rsp_if.source rsp_ch
);
   import dnd_pkg::*;

   logic [7:0] pkt_mem [PACKET_BYTES];
   logic [7:0] rd_data_ff;
   logic              rd_en;
   logic [PKT_AW-1:0] rd_addr;
   logic              wr_en;
   logic [POS_W-1:0]  req_pos;

   walk_state_type    state_ff, state_in;
   part_kind_type     kind_ff, kind_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        remain_ff, remain_in;
   logic              first_ff, first_in;
   logic              seen_ff, seen_in;
   logic [9:0]        used_ff, used_in;
   logic [NAME_W-1:0] name_len_ff, name_len_in;
   logic [7:0]        grp_ff [4];
   logic [7:0]        grp_in [4];
   logic [2:0]        grp_cnt_ff, grp_cnt_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic       out_free;
   logic       put_req;
   logic [7:0] put_chr;
   logic       name_full;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign req_pos   = POS_W'(req_ch.payload.addr);
   assign wr_en     = req_ch.valid && req_ch.ready && (req_ch.payload.req_type == REQ_WRITE)
                      && (req_pos < POS_W'(PACKET_BYTES));
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign name_full = (name_len_ff >= NAME_W'(NAME_MAX_CHARS));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pkt_mem[req_pos[PKT_AW-1:0]] <= req_ch.payload.data;
      end
      if (rd_en) begin
         rd_data_ff <= pkt_mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      remain_in    = remain_ff;
      first_in     = first_ff;
      seen_in      = seen_ff;
      used_in      = used_ff;
      name_len_in  = name_len_ff;
      grp_in       = grp_ff;
      grp_cnt_in   = grp_cnt_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff[PKT_AW-1:0];
      put_req      = 1'b0;
      put_chr      = rd_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid && (req_ch.payload.req_type == REQ_DECODE)) begin
               state_in    = S_WALK;
               kind_in     = K_LEN;
               pos_in      = req_pos;
               first_in    = 1'b1;
               seen_in     = 1'b0;
               used_in     = '0;
               name_len_in = '0;
               grp_in      = '{default: 8'd0};
               grp_cnt_in  = '0;
               status_in   = ST_OK;
               rd_en       = 1'b1;
               rd_addr     = req_pos[PKT_AW-1:0];
            end
         end

         S_WALK: begin
            // The byte at pos_ff sits in rd_data_ff unless pos_ff is past the store.
            if (pos_ff >= POS_W'(PACKET_BYTES)) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               unique case (kind_ff)
                  K_LEN: begin
                     if (first_ff) begin
                        used_in = used_ff + 10'd1;
                     end
                     if (rd_data_ff == 8'd0) begin
                        status_in = ST_OK;
                        state_in  = S_DONE;
                     end else if (first_ff && (rd_data_ff == PTR_MARK)) begin
                        kind_in = K_PTR;
                        pos_in  = pos_ff + POS_W'(1);
                     end else if (seen_ff && name_full) begin
                        status_in = ST_TOO_LONG;
                        state_in  = S_DONE;
                     end else begin
                        put_req   = seen_ff;
                        put_chr   = DOT_CHAR;
                        seen_in   = 1'b1;
                        kind_in   = K_LABEL;
                        remain_in = rd_data_ff;
                        pos_in    = pos_ff + POS_W'(1);
                     end
                  end

                  K_PTR: begin
                     used_in  = used_ff + 10'd1;
                     first_in = 1'b0;
                     kind_in  = K_LEN;
                     pos_in   = POS_W'(rd_data_ff);
                  end

                  K_LABEL: begin
                     if (first_ff) begin
                        used_in = used_ff + 10'd1;
                     end
                     if (name_full) begin
                        status_in = ST_TOO_LONG;
                        state_in  = S_DONE;
                     end else begin
                        put_req   = 1'b1;
                        remain_in = remain_ff - 8'd1;
                        if (remain_ff == 8'd1) begin
                           kind_in = K_LEN;
                        end
                        pos_in = pos_ff + POS_W'(1);
                     end
                  end

                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end

            if (put_req) begin
               name_len_in = name_len_ff + NAME_W'(1);
               if (grp_cnt_ff == GROUP_FULL) begin
                  // A full group goes out only once another character proves it is not last.
                  rsp_valid_in       = 1'b1;
                  rsp_in.char_a      = grp_ff[0];
                  rsp_in.char_b      = grp_ff[1];
                  rsp_in.char_c      = grp_ff[2];
                  rsp_in.char_d      = grp_ff[3];
                  rsp_in.char_count  = GROUP_FULL;
                  rsp_in.last        = 1'b0;
                  rsp_in.consumed    = '0;
                  rsp_in.status      = ST_OK;
                  grp_in             = '{default: 8'd0};
                  grp_in[0]          = put_chr;
                  grp_cnt_in         = 3'd1;
               end else begin
                  grp_in[grp_cnt_ff[1:0]] = put_chr;
                  grp_cnt_in              = grp_cnt_ff + 3'd1;
               end
            end

            if (put_req && (grp_cnt_ff == GROUP_FULL) && !out_free) begin
               // Output slot busy: hold the walk; the read data register keeps its byte.
               state_in     = state_ff;
               kind_in      = kind_ff;
               pos_in       = pos_ff;
               remain_in    = remain_ff;
               first_in     = first_ff;
               seen_in      = seen_ff;
               used_in      = used_ff;
               name_len_in  = name_len_ff;
               grp_in       = grp_ff;
               grp_cnt_in   = grp_cnt_ff;
               status_in    = status_ff;
               rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
               rsp_in       = rsp_ff;
            end else if (state_in == S_WALK) begin
               rd_en   = 1'b1;
               rd_addr = pos_in[PKT_AW-1:0];
            end
         end

         S_DONE: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.char_a     = grp_ff[0];
               rsp_in.char_b     = grp_ff[1];
               rsp_in.char_c     = grp_ff[2];
               rsp_in.char_d     = grp_ff[3];
               rsp_in.char_count = grp_cnt_ff;
               rsp_in.last       = 1'b1;
               rsp_in.consumed   = used_ff;
               rsp_in.status     = status_ff;
               state_in          = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      remain_ff   <= remain_in;
      first_ff    <= first_in;
      seen_ff     <= seen_in;
      used_ff     <= used_in;
      name_len_ff <= name_len_in;
      grp_ff      <= grp_in;
      grp_cnt_ff  <= grp_cnt_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

endmodule

/* rtl/dnd_checker.sv */
// ----------------------------------------------------------------------------
// dnd_checker
// Port-level checks of the name decompressor, attached by bind.
// ----------------------------------------------------------------------------
module dnd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_type,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input dnd_pkg::rsp_payload_type rsp_payload
);
   import dnd_pkg::*;

   // A result that is not taken must stay offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // Only the final group of a name may be short, and it alone reports progress.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |->
         (rsp_payload.char_count == GROUP_FULL) && (rsp_payload.consumed == 10'd0)
         && (rsp_payload.status == ST_OK))
      else $error("intermediate group is not full or carries a summary");

   // Once a decode request is taken, no further request is taken in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_DECODE) |=> !req_ready)
      else $error("request taken while a name walk is running");

   // Unused character slots are zero; only the fourth slot, char_d, is checked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.char_count < GROUP_FULL) |-> (rsp_payload.char_d == 8'd0))
      else $error("character beyond count is not zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.status == ST_OK) || (rsp_payload.status == ST_TOO_LONG)
                     || (rsp_payload.status == ST_RANGE))
                    && (rsp_payload.char_count <= GROUP_FULL))
      else $error("result field out of range");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_type    (req_ch.payload.req_type),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);
